### rtl/core/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define SCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds during reset
`define SCC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scc_pkg.sv
package scc_pkg;

  // frame limits and fixed point format
  localparam int MAX_WIDTH        = 2048;
  localparam int MAX_HEIGHT       = 2048;
  localparam int WEIGHT_FRAC_BITS = 12;

  // field widths
  localparam int CFG_DIM_W = 12;
  localparam int WEIGHT_W  = 16;
  localparam int SAMPLE_W  = 8;
  localparam int GREY_MAX  = (1 << SAMPLE_W) - 1;

  // counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 3);

  // datapath widths
  localparam int TAPS   = 3;
  localparam int PROD_W = WEIGHT_W + SAMPLE_W + 1;
  localparam int CSUM_W = PROD_W + 2;
  localparam int ACC_W  = CSUM_W + 2;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // register port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [CFG_DIM_W-1:0]       RST_FRAME_WIDTH   = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0]       RST_FRAME_HEIGHT  = CFG_DIM_W'(480);
  localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_CENTRE = WEIGHT_W'(6827);
  localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_EDGE   = -WEIGHT_W'(341);
  localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_CORNER = -WEIGHT_W'(341);

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_WEIGHT_CENTRE = 3'd2,
    REG_WEIGHT_EDGE   = 3'd3,
    REG_WEIGHT_CORNER = 3'd4
  } reg_idx_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // one window column, index is the tap row (0 = oldest row)
  typedef sample_t [TAPS-1:0] column_t;

  // which taps of one column lie inside the frame
  typedef struct packed {
    logic [TAPS-1:0] row_en;
    logic            col_en;
  } tap_mask_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] grey;
    logic                last;
  } result_t;

endpackage

### rtl/core/scc_cell.sv
module scc_cell import scc_pkg::*; (
  input  logic                       clk,
  input  logic                       shift,
  input  column_t                    col_in,
  output column_t                    col_out,
  input  logic signed [WEIGHT_W-1:0] weight_outer,
  input  logic signed [WEIGHT_W-1:0] weight_mid,
  input  tap_mask_t                  mask,
  output logic signed [CSUM_W-1:0]   psum
);

  column_t                    taps;
  logic signed [SAMPLE_W:0]   smp  [TAPS];
  logic signed [WEIGHT_W-1:0] wsel [TAPS];
  logic signed [PROD_W-1:0]   prod [TAPS];
  logic signed [CSUM_W-1:0]   psum_next;

  assign col_out = taps;

  always_comb begin
    psum_next = '0;
    for (int i = 0; i < TAPS; i++) begin
      smp[i]  = {1'b0, taps[i]};
      wsel[i] = (i == 1) ? weight_mid : weight_outer;
      prod[i] = '0;
      if (mask.row_en[i] && mask.col_en) begin
        prod[i] = wsel[i] * smp[i];
      end
      psum_next = psum_next + CSUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      taps <= col_in;
    end
    psum <= psum_next;
  end

endmodule

### rtl/core/scc_out_fifo.sv
module scc_out_fifo import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  result_t            push_data,
  input  logic               pop,
  output logic               valid,
  output result_t            head_data,
  output logic [FIFO_CW-1:0] count
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head;
  logic [FIFO_AW-1:0]   tail;

  assign valid     = (count != '0);
  assign head_data = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule

### rtl/core/sharpen_convolution_3x3_core.sv
// a result is offered from the output queue once the item that completes its neighbourhood
//   (one row plus one pixel after its own sample) has passed stages a, b, c and d
// throughput: one item per cycle while the result queue has room, set by the single line memory
//   read and write per item; on a one-row frame the first flush takes two column steps
// reset: synchronous, restores register defaults, counters and result queue; line memory keeps
//   its contents
module sharpen_convolution_3x3_core import scc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // pixel items
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic                kind,
  input  logic [SAMPLE_W-1:0] sample,
  // result items
  output logic                result_valid,
  input  logic                result_ready,
  output logic [SAMPLE_W-1:0] grey,
  output logic                last
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DIM_W-1:0]       frame_width;
  logic [CFG_DIM_W-1:0]       frame_height;
  logic signed [WEIGHT_W-1:0] weight_centre;
  logic signed [WEIGHT_W-1:0] weight_edge;
  logic signed [WEIGHT_W-1:0] weight_corner;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      weight_centre <= RST_WEIGHT_CENTRE;
      weight_edge   <= RST_WEIGHT_EDGE;
      weight_corner <= RST_WEIGHT_CORNER;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:   frame_width   <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[CFG_DIM_W-1:0];
        REG_WEIGHT_CENTRE: weight_centre <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_EDGE:   weight_edge   <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_CORNER: weight_corner <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, unused addresses read as zero
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:   prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT:  prdata = APB_DW'(frame_height);
      REG_WEIGHT_CENTRE: prdata = APB_DW'(unsigned'(weight_centre));
      REG_WEIGHT_EDGE:   prdata = APB_DW'(unsigned'(weight_edge));
      REG_WEIGHT_CORNER: prdata = APB_DW'(unsigned'(weight_corner));
      default:           prdata = '0;
    endcase
  end

  // effective frame size: zero acts as one, oversize is clipped to the maximum
  logic [WDIM_W-1:0] eff_w;
  logic [HDIM_W-1:0] eff_h;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WDIM_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WDIM_W'(MAX_WIDTH);
    end else begin
      eff_w = WDIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HDIM_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HDIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = HDIM_W'(frame_height);
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: position counters and the column step decision
  // ---------------------------------------------------------------------------
  logic [IROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]  in_col, in_col_next;
  logic [OROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0]  out_col, out_col_next;

  logic              complete;     // every pixel of the frame has arrived
  logic              emit_now;     // a column step here finishes an output pixel
  logic              bubble;       // flush that needs a silent column step first
  logic              space_ok;
  logic              accept;
  logic              adv;          // one column step happens this cycle
  logic              emit;
  logic [SAMPLE_W-1:0] step_sample;

  logic [WDIM_W-1:0] col_plus;
  logic              col_wrap;
  logic [WDIM_W-1:0] ocol_plus;
  logic [HDIM_W-1:0] orow_plus;
  logic              o_wrap;
  logic              is_last;
  logic [TAPS-1:0]   row_en;
  logic [TAPS-1:0]   col_en;

  // result queue bookkeeping
  logic               s1_emit, s2_emit, s3_emit;
  logic [FIFO_CW-1:0] fifo_count;

  assign complete = in_row >= IROW_W'(eff_h);
  assign emit_now = (in_row >= IROW_W'(2)) || ((in_row == IROW_W'(1)) && (in_col != '0));

  // one-row frame: the first flush steps over the first column of the
  // virtual row silently, then is taken and gives its result
  assign bubble   = pixel_valid && kind && complete && !emit_now;

  // reserve room for every result still in the pipe plus this one
  assign space_ok = (int'(fifo_count) + int'(s1_emit) + int'(s2_emit) + int'(s3_emit))
                    < FIFO_DEPTH;

  assign pixel_ready = space_ok && !bubble;
  assign accept      = pixel_valid && pixel_ready;

  // pixels count only before the frame is complete, flushes only after
  assign adv         = bubble || (accept && (kind ? complete : !complete));
  assign emit        = adv && emit_now;
  assign step_sample = kind ? '0 : sample;

  assign col_plus  = WDIM_W'(in_col) + WDIM_W'(1);
  assign col_wrap  = col_plus >= eff_w;
  assign ocol_plus = WDIM_W'(out_col) + WDIM_W'(1);
  assign orow_plus = HDIM_W'(out_row) + HDIM_W'(1);
  assign o_wrap    = ocol_plus >= eff_w;
  assign is_last   = (orow_plus >= eff_h) && o_wrap;

  // taps outside the frame drop out; the newest column is empty when the
  // step wraps onto a new row
  always_comb begin
    row_en[0] = (out_row != '0) && (HDIM_W'(out_row) <= eff_h);
    row_en[1] = HDIM_W'(out_row) < eff_h;
    row_en[2] = orow_plus < eff_h;
    col_en[0] = (out_col != '0) && (WDIM_W'(out_col) <= eff_w);
    col_en[1] = WDIM_W'(out_col) < eff_w;
    col_en[2] = (ocol_plus < eff_w) && (in_col != '0);
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (adv) begin
      if (col_wrap) begin
        in_col_next = '0;
        if (in_row != '1) begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_col_next = col_plus[COL_W-1:0];
      end
      if (emit) begin
        if (is_last) begin
          // end of frame: everything back to the origin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (o_wrap) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // ---------------------------------------------------------------------------
  // line memory: per column the two previous rows, upper byte older
  // ---------------------------------------------------------------------------
  logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_W-1:0] mem_q;
  logic [2*SAMPLE_W-1:0] ls_fwd;
  logic [2*SAMPLE_W-1:0] ls;
  logic [2*SAMPLE_W-1:0] ls_wdata;

  // stage b registers
  logic                s1_adv;
  logic [COL_W-1:0]    s1_col;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_hazard;
  logic                s1_last;
  logic [TAPS-1:0]     s1_row_en;
  logic [TAPS-1:0]     s1_col_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_adv  <= 1'b0;
      s1_emit <= 1'b0;
    end else begin
      s1_adv  <= adv;
      s1_emit <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col    <= in_col;
      s1_sample <= step_sample;
      // back to back steps on the same column (one pixel wide frame):
      // the memory still holds the old word, take the one just written
      s1_hazard <= s1_adv && (s1_col == in_col);
      s1_last   <= is_last;
      s1_row_en <= row_en;
      s1_col_en <= col_en;
    end
  end

  // read in stage a, read-modify-write completes in stage b
  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= line_mem[in_col];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= ls_wdata;
    end
  end

  assign ls       = s1_hazard ? ls_fwd : mem_q;
  assign ls_wdata = {ls[SAMPLE_W-1:0], s1_sample};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ls_fwd <= ls_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // window: chain of three column cells, newest column enters cell 2 and
  // moves one cell towards cell 0 on every column step
  // ---------------------------------------------------------------------------
  column_t                    new_col;
  column_t                    cell_col  [TAPS];
  logic signed [CSUM_W-1:0]   cell_psum [TAPS];
  tap_mask_t                  cell_mask [TAPS];

  // stage c control, aligned with the window that the cells hold
  logic                s2_last;
  logic [TAPS-1:0]     s2_row_en;
  logic [TAPS-1:0]     s2_col_en;

  always_comb begin
    new_col[0] = ls[2*SAMPLE_W-1:SAMPLE_W];
    new_col[1] = ls[SAMPLE_W-1:0];
    new_col[2] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else begin
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_last   <= s1_last;
    s2_row_en <= s1_row_en;
    s2_col_en <= s1_col_en;
  end

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    column_t col_feed;

    if (j == TAPS - 1) begin : g_head
      assign col_feed = new_col;
    end else begin : g_body
      assign col_feed = cell_col[j+1];
    end

    assign cell_mask[j] = '{row_en: s2_row_en, col_en: s2_col_en[j]};

    // middle column carries edge and centre, outer columns corner and edge
    scc_cell u_cell (
      .clk          (clk),
      .shift        (s1_adv),
      .col_in       (col_feed),
      .col_out      (cell_col[j]),
      .weight_outer ((j == 1) ? weight_edge : weight_corner),
      .weight_mid   ((j == 1) ? weight_centre : weight_edge),
      .mask         (cell_mask[j]),
      .psum         (cell_psum[j])
    );
  end

  // ---------------------------------------------------------------------------
  // stage d: add the column sums, clamp and queue the result
  // ---------------------------------------------------------------------------
  logic                    s3_last;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_shift;
  logic [SAMPLE_W-1:0]     grey_calc;
  result_t                 push_data;
  result_t                 head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else begin
      s3_emit <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      acc = acc + ACC_W'(cell_psum[j]);
    end
    acc_shift = acc >>> WEIGHT_FRAC_BITS;
    // negative gives black, fraction dropped, saturate at white
    if (acc < 0) begin
      grey_calc = '0;
    end else if (acc_shift > ACC_W'(GREY_MAX)) begin
      grey_calc = SAMPLE_W'(GREY_MAX);
    end else begin
      grey_calc = acc_shift[SAMPLE_W-1:0];
    end
  end

  assign push_data = '{grey: grey_calc, last: s3_last};

  scc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_emit),
    .push_data (push_data),
    .pop       (result_valid && result_ready),
    .valid     (result_valid),
    .head_data (head_data),
    .count     (fifo_count)
  );

  assign grey = head_data.grey;
  assign last = head_data.last;

endmodule

### rtl/core/scc_checker.sv
`include "assert_macros.svh"

module scc_checker import scc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                pixel_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [SAMPLE_W-1:0] grey,
  input logic                last
);

  // a stalled result stays offered
  `SCC_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `SCC_ASSERT(a_result_stable, result_valid && !result_ready |=> $stable(grey) && $stable(last), "result payload changed while stalled")

  // reset empties the result queue and the pipe
  `SCC_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result offered straight after reset")

  // after reset the block takes items at once
  `SCC_ASSERT_RST(a_reset_ready, rst |=> pixel_ready, "not ready straight after reset")

endmodule

bind sharpen_convolution_3x3_core scc_checker u_scc_checker (.*);

### tb/sv/sharpen_convolution_3x3_core_tb.sv
module sharpen_convolution_3x3_core_tb import scc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // item kinds on the pixel channel
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // cycles without any accepted item before the run is abandoned
  localparam int STALL_LIMIT = 5000;
  // settling time after the last result, covers the pipeline and queue
  localparam int SETTLE_CYCLES = 12;
  // target number of counted items in the random part
  localparam int RANDOM_ITEMS = 700;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic    kind;
    sample_t sample;
  } pixel_item_t;

  // 3x3 neighbourhood, first index is the row (0 = oldest)
  typedef sample_t [2:0][2:0] patch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // pixel items
  logic    pixel_valid = 1'b0;
  logic    pixel_ready;
  logic    kind        = KIND_PIXEL;
  sample_t sample      = '0;

  // result items
  logic    result_valid;
  logic    result_ready = 1'b0;
  sample_t grey;
  logic    last;

  sharpen_convolution_3x3_core DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .kind         (kind),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .grey         (grey),
    .last         (last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be sent, and filtered pixels still owed by the block
  pixel_item_t pixel_queue[$];
  result_t     sharpened_due[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned stall_cycles   = 0;
  int unsigned counted_items  = 0;

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and of the filter state
  // ---------------------------------------------------------------------------
  logic [CFG_DIM_W-1:0]       cfg_width  = RST_FRAME_WIDTH;
  logic [CFG_DIM_W-1:0]       cfg_height = RST_FRAME_HEIGHT;
  logic signed [WEIGHT_W-1:0] w_centre   = RST_WEIGHT_CENTRE;
  logic signed [WEIGHT_W-1:0] w_edge     = RST_WEIGHT_EDGE;
  logic signed [WEIGHT_W-1:0] w_corner   = RST_WEIGHT_CORNER;

  // two previous rows per column, upper byte is the older one
  logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  patch_t                win     = '0;
  int unsigned           in_row  = 0;
  int unsigned           in_col  = 0;
  int unsigned           out_row = 0;
  int unsigned           out_col = 0;

  // zero means one, oversize clips to the maximum
  function automatic int unsigned eff_dim(logic [CFG_DIM_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // weighted sum of the taps inside the frame, clamped to a grey level
  function automatic sample_t weigh_patch(patch_t t, int unsigned w, int unsigned h);
    longint acc, rr, cc, wt;
    acc = 0;
    for (int dr = 0; dr < 3; dr++) begin
      rr = longint'(out_row) + dr - 1;
      if (rr >= 0 && rr < longint'(h)) begin
        for (int dc = 0; dc < 3; dc++) begin
          cc = longint'(out_col) + dc - 1;
          if (cc >= 0 && cc < longint'(w)) begin
            if (dr == 1 && dc == 1) wt = w_centre;
            else if (dr == 1 || dc == 1) wt = w_edge;
            else wt = w_corner;
            acc += wt * longint'(t[dr][dc]);
          end
        end
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> WEIGHT_FRAC_BITS;
    if (acc > GREY_MAX) return sample_t'(GREY_MAX);
    return sample_t'(acc);
  endfunction

  // one column step of the window; returns 1 when a pixel comes out
  function automatic bit slide_window(sample_t pix, output result_t res);
    int unsigned     w, h, r, c;
    bit              emit;
    logic [15:0]     held;
    patch_t          t;
    w = eff_dim(cfg_width, MAX_WIDTH);
    h = eff_dim(cfg_height, MAX_HEIGHT);
    r = in_row;
    c = in_col;
    emit = (r >= 2) || (r == 1 && c >= 1);
    t = '0;
    res = '0;
    // row wrap: the patch is the window before this column shifts in
    if (emit && c == 0) begin
      for (int i = 0; i < 3; i++) begin
        t[i][0] = win[i][1];
        t[i][1] = win[i][2];
        t[i][2] = '0;
      end
    end
    held = line_mem[c];
    line_mem[c] = {held[7:0], pix};
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = held[15:8];
    win[1][2] = held[7:0];
    win[2][2] = pix;
    if (emit && c != 0) t = win;
    if (c + 1 >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;
    end else begin
      in_col = c + 1;
    end
    if (emit) begin
      res.grey = weigh_patch(t, w, h);
      res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (res.last) begin
        win = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
    return emit;
  endfunction

  // expected result of one accepted item
  function automatic void sharpen_item(logic item_kind, sample_t item_sample);
    result_t res;
    bit      complete;
    complete = in_row >= eff_dim(cfg_height, MAX_HEIGHT);
    if (item_kind == KIND_PIXEL) begin
      // pixels after a complete frame are dropped until it has drained
      if (!complete && slide_window(item_sample, res)) sharpened_due.push_back(res);
    end else if (complete) begin
      // a flush may need two column steps before a pixel comes out
      if (slide_window('0, res)) sharpened_due.push_back(res);
      else if (slide_window('0, res)) sharpened_due.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    pixel_item_t nxt;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) sharpen_item(kind, sample);
      // slot is free once the held item has gone
      if (!pixel_valid || pixel_ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pixel_queue.pop_front();
          pixel_valid <= 1'b1;
          kind        <= nxt.kind;
          sample      <= nxt.sample;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (sharpened_due.size() == 0) begin
          $error("unexpected result item: grey %0d last %0b", grey, last);
          mismatches++;
        end else begin
          want = sharpened_due.pop_front();
          if (grey !== want.grey) begin
            $error("grey mismatch: expected %0d, got %0d", want.grey, grey);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, last);
            mismatches++;
          end
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("** sharpen_convolution_3x3_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic item_kind, sample_t item_sample);
    pixel_queue.push_back(pixel_item_t'{kind: item_kind, sample: item_sample});
  endfunction

  // grey levels with the extremes favoured
  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return WEIGHT_W'($urandom);
      default: return WEIGHT_W'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  // whole frame of w x h pixels then the flushes that drain it;
  // noise adds early flushes, stray pixels while draining and spare flushes
  function automatic void queue_frame(int unsigned w, int unsigned h, bit noisy);
    int unsigned n_flush;
    n_flush = (h == 1) ? w : w + 1;
    for (int unsigned k = 0; k < w * h; k++) begin
      if (noisy && $urandom_range(99) < 4) push_item(KIND_FLUSH, random_sample());
      push_item(KIND_PIXEL, random_sample());
    end
    for (int unsigned k = 0; k < n_flush; k++) begin
      if (noisy && $urandom_range(99) < 8) push_item(KIND_PIXEL, random_sample());
      push_item(KIND_FLUSH, random_sample());
    end
    if (noisy && $urandom_range(3) == 0) push_item(KIND_FLUSH, random_sample());
    counted_items += w * h + n_flush;
  endfunction

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 77; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default:       begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endfunction

  // setup then access cycle; predictor follows once the write has landed
  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   cfg_width  = value[CFG_DIM_W-1:0];
      REG_FRAME_HEIGHT:  cfg_height = value[CFG_DIM_W-1:0];
      REG_WEIGHT_CENTRE: w_centre   = value[WEIGHT_W-1:0];
      REG_WEIGHT_EDGE:   w_edge     = value[WEIGHT_W-1:0];
      default:           w_corner   = value[WEIGHT_W-1:0];
    endcase
  endtask

  task automatic configure(logic [CFG_DIM_W-1:0] w_raw, logic [CFG_DIM_W-1:0] h_raw,
                           logic [WEIGHT_W-1:0] centre, logic [WEIGHT_W-1:0] side,
                           logic [WEIGHT_W-1:0] corner);
    write_reg(REG_FRAME_WIDTH, APB_DW'(w_raw));
    write_reg(REG_FRAME_HEIGHT, APB_DW'(h_raw));
    write_reg(REG_WEIGHT_CENTRE, APB_DW'(centre));
    write_reg(REG_WEIGHT_EDGE, APB_DW'(side));
    write_reg(REG_WEIGHT_CORNER, APB_DW'(corner));
  endtask

  // every item sent and every result back, then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pixel_valid || sharpened_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DIM_W-1:0] w_raw, h_raw;
    int unsigned          phase_no, random_start, frames, w_eff, h_eff;

    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: 3x3 checkerboard with the sharpening kernel
    set_idling(IDLE_NONE);
    configure(12'd3, 12'd3, RST_WEIGHT_CENTRE, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
    for (int k = 0; k < 9; k++) begin
      push_item(KIND_PIXEL, (k % 2) ? 8'd0 : 8'd255);
      // flush before the frame is complete is dropped
      if (k == 2) push_item(KIND_FLUSH, 8'hA5);
    end
    push_item(KIND_FLUSH, 8'hFF);
    // pixel after the frame, before it has drained, is dropped
    push_item(KIND_PIXEL, 8'h5A);
    repeat (3) push_item(KIND_FLUSH, 8'h00);
    // spare flush after the last pixel is dropped as well
    push_item(KIND_FLUSH, 8'h3C);
    counted_items += 13;
    wait_drained();

    // zero sizes act as a single pixel; one-row frame needs a double-step flush
    configure(12'd0, 12'd0, 16'h7FFF, 16'h8000, 16'h8000);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_FLUSH, 8'd0);
    counted_items += 2;
    wait_drained();

    // single column: centre at its minimum, neighbours at their maximum
    configure(12'd1, 12'd3, 16'h8000, 16'h7FFF, 16'h7FFF);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd0);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_FLUSH, 8'd0);
    push_item(KIND_FLUSH, 8'd255);
    counted_items += 5;
    wait_drained();

    // random phases, cycling through the idling modes
    phase_no = 0;
    random_start = counted_items;
    while (counted_items - random_start < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'(phase_no % 4));
      case ($urandom_range(9))
        0:       w_raw = '0;
        1:       w_raw = CFG_DIM_W'($urandom_range(13, 24));
        default: w_raw = CFG_DIM_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
        0:       h_raw = '0;
        1:       h_raw = CFG_DIM_W'($urandom_range(9, 12));
        default: h_raw = CFG_DIM_W'($urandom_range(1, 8));
      endcase
      // real sharpening kernel often, so that results are not all clamped
      if ($urandom_range(9) < 4)
        configure(w_raw, h_raw, RST_WEIGHT_CENTRE, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
      else
        configure(w_raw, h_raw, random_weight(), random_weight(), random_weight());
      w_eff = eff_dim(w_raw, MAX_WIDTH);
      h_eff = eff_dim(h_raw, MAX_HEIGHT);
      frames = (w_eff * h_eff > 64) ? 1 : $urandom_range(1, 3);
      repeat (frames) queue_frame(w_eff, h_eff, 1'b1);
      wait_drained();
      phase_no++;
    end

    if (mismatches == 0 && sharpened_due.size() == 0) begin
      $display("** sharpen_convolution_3x3_core: PASSED **");
    end else begin
      $display("** sharpen_convolution_3x3_core: FAILED **");
    end
    $finish;
  end

endmodule
